@@ rtl/asd_pkg.sv @@
// shared types and constants of the step detector
`default_nettype none

package asd_pkg;

   localparam int AXIS_W     = 16;
   localparam int COUNT_W    = 32;
   localparam int LEVEL_W    = 16;
   localparam int SUM_W      = 32;
   localparam int SQRT_ITER  = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 8'd3;

   localparam logic MODE_ACCEL = 1'b0;
   localparam logic MODE_EDGE  = 1'b1;

   localparam logic [15:0] THRESHOLD_RESET  = 16'd100;
   localparam logic [7:0]  REFRACTORY_RESET = 8'd5;
   localparam logic [15:0] TARGET_RESET     = 16'd100;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] operand;
   } asd_root_req_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] root;
   } asd_root_status_type;

endpackage

`default_nettype wire

@@ rtl/asd_isqrt.sv @@
// iterative restoring integer square root, two operand bits per cycle
`default_nettype none

module asd_isqrt
   import asd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire asd_root_req_type    root_req,
   output asd_root_status_type      root_status
);

   localparam int ROOT_W = LEVEL_W + 2;
   localparam int REM_W  = LEVEL_W + 4;
   localparam int ITER_W = $clog2(SQRT_ITER);
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(SQRT_ITER - 1);

   logic [SUM_W-1:0]  v_ff, v_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [ROOT_W-1:0] root_sh;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  rem_sub;
   logic              take;

   always_comb begin
      root_sh = {root_ff[ROOT_W-2:0], 1'b0};
      rem_sh  = {rem_ff[REM_W-3:0], v_ff[SUM_W-1 -: 2]};
      take    = REM_W'(root_sh) < rem_sh;
      rem_sub = rem_sh - REM_W'(root_sh | ROOT_W'(1));

      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (root_req.start) begin
         v_in    = root_req.operand;
         rem_in  = '0;
         root_in = '0;
         iter_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         v_in    = {v_ff[SUM_W-3:0], 2'b00};
         rem_in  = take ? rem_sub : rem_sh;
         root_in = take ? root_sh + ROOT_W'(2) : root_sh;
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_status.done = done_ff;
   assign root_status.root = root_ff[LEVEL_W:1];

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      root_req.start |=> busy_ff && !done_ff)
      else $error("root unit did not start");

   a_last_iter_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && iter_ff == LAST_ITER && !root_req.start |=> done_ff && !busy_ff)
      else $error("root unit did not finish after its last iteration");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("root unit busy and done together");

endmodule

`default_nettype wire

@@ rtl/accel_step_detector.sv @@
// step detector top level: sequencer, shared squarer, baseline and counters
//
// req channel carries one tick: three signed axis samples, the interrupt
// level (tdata) and the read success flag (tuser). rsp carries one item per
// tick with the counts and levels after that tick. csr writes one of four
// registers (mode, step threshold, refractory ticks, batch target); it is
// always ready; the user must write it only while the block is idle, and the
// block itself does not enforce this. In accelerometer mode with a good read
// an item goes from the accepting edge through the one shared squarer, the
// two-bit-per-cycle square root unit, then the baseline, step and output
// states before rsp_tvalid rises. A failed read or an edge mode tick goes
// straight to the step and output states. One item is worked on at a time;
// req_tready is high only while the sequencer is idle, so no new item is
// taken while the sequencer works on the last one. The result sits in an
// output register, so the next item is accepted while it waits; if rsp_tready
// stays low, the next result holds in the output state and blocks new items.
// Reset (synchronous, active high) clears all counts and the refractory
// counter, loads the baseline with ONE_G_LEVEL and the registers with their
// defaults, and drops rsp_tvalid.
`default_nettype none

module accel_step_detector
   import asd_pkg::*;
#(
   parameter int ACC_SHIFT      = 2,
   parameter int BASELINE_SHIFT = 4,
   parameter int ONE_G_LEVEL    = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // accel_x, accel_y, accel_z, int_level, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // read_ok
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // batch_total, lifetime_total, magnitude, gravity_level, bus_error_total
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // step_counted, wake_host
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_ROOT   = 3'd2;
   localparam logic [2:0] ST_BASE   = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   localparam int DIFF_W = LEVEL_W + 2;

   logic                    mode_ff;
   logic [15:0]             thr_ff;
   logic [7:0]              refr_ticks_ff;
   logic [15:0]             target_ff;

   logic [2:0]              state_ff, state_in;
   logic signed [AXIS_W-1:0] axis_ff [3];
   logic signed [AXIS_W-1:0] axis_in [3];
   logic                    read_ok_ff, read_ok_in;
   logic                    level_ff, level_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [SUM_W-1:0]        prod_ff, prod_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [LEVEL_W-1:0]      mag_ff, mag_in;
   logic [LEVEL_W-1:0]      grav_ff, grav_in;
   logic [7:0]              refr_ff, refr_in;
   logic                    prev_ff, prev_in;
   logic [COUNT_W-1:0]      batch_ff, batch_in;
   logic [COUNT_W-1:0]      life_ff, life_in;
   logic [COUNT_W-1:0]      err_ff, err_in;
   logic                    counted_ff, counted_in;
   logic                    check_ff, check_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                    accept;
   logic                    rsp_load;
   logic signed [AXIS_W-1:0] axis_sel;
   logic signed [SUM_W-1:0] square;
   logic signed [DIFF_W-1:0] resid;
   logic signed [DIFF_W-1:0] adj;
   logic signed [DIFF_W-1:0] base_new;
   logic                    wake;

   asd_root_req_type        root_req;
   asd_root_status_type     root_status;

   asd_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .root_req    (root_req),
      .root_status (root_status)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ACCEL;
         thr_ff        <= THRESHOLD_RESET;
         refr_ticks_ff <= REFRACTORY_RESET;
         target_ff     <= TARGET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:       mode_ff       <= csr_data[0];
            CSR_THRESHOLD:  thr_ff        <= csr_data[15:0];
            CSR_REFRACTORY: refr_ticks_ff <= csr_data[7:0];
            CSR_TARGET:     target_ff     <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cnt_ff)
         2'd0:    axis_sel = axis_ff[0];
         2'd1:    axis_sel = axis_ff[1];
         default: axis_sel = axis_ff[2];
      endcase
      square   = SUM_W'(axis_sel) * SUM_W'(axis_sel);
      resid    = $signed({2'b00, mag_ff}) - $signed({2'b00, grav_ff});
      adj      = resid >>> BASELINE_SHIFT;
      base_new = $signed({2'b00, grav_ff}) + adj;
      wake     = check_ff && (batch_ff >= COUNT_W'(target_ff));
      rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   assign root_req.start   = (state_ff == ST_SQUARE) && (cnt_ff == 2'd3);
   assign root_req.operand = sum_ff + prod_ff;

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      read_ok_in  = read_ok_ff;
      level_in    = level_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      sum_in      = sum_ff;
      mag_in      = mag_ff;
      grav_in     = grav_ff;
      refr_in     = refr_ff;
      prev_in     = prev_ff;
      batch_in    = batch_ff;
      life_in     = life_ff;
      err_in      = err_ff;
      counted_in  = counted_ff;
      check_in    = check_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               axis_in[0] = $signed(req_tdata[15:0]) >>> ACC_SHIFT;
               axis_in[1] = $signed(req_tdata[31:16]) >>> ACC_SHIFT;
               axis_in[2] = $signed(req_tdata[47:32]) >>> ACC_SHIFT;
               level_in   = req_tdata[48];
               read_ok_in = req_tuser;
               cnt_in     = '0;
               sum_in     = '0;
               if (mode_ff == MODE_EDGE || !req_tuser) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            prod_in = unsigned'(square);
            if (cnt_ff != 2'd0) begin
               sum_in = sum_ff + prod_ff;
            end
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_status.done) begin
               mag_in   = root_status.root;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            grav_in  = base_new[LEVEL_W-1:0];
            state_in = ST_STEP;
         end
         ST_STEP: begin
            counted_in = 1'b0;
            check_in   = 1'b1;
            if (mode_ff == MODE_EDGE) begin
               counted_in = level_ff && !prev_ff;
               prev_in    = level_ff;
            end else if (!read_ok_ff) begin
               err_in   = err_ff + COUNT_W'(1);
               check_in = 1'b0;
            end else if (refr_ff != 8'd0) begin
               refr_in  = refr_ff - 8'd1;
               check_in = 1'b0;
            end else if (resid > $signed({2'b00, thr_ff})) begin
               counted_in = 1'b1;
               refr_in    = refr_ticks_ff;
            end
            if (counted_in) begin
               batch_in = batch_ff + COUNT_W'(1);
               life_in  = life_ff + COUNT_W'(1);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {err_ff, grav_ff, mag_ff, life_ff, batch_ff};
               rsp_user_in  = {wake, counted_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grav_ff      <= LEVEL_W'(ONE_G_LEVEL);
         mag_ff       <= '0;
         refr_ff      <= '0;
         prev_ff      <= 1'b0;
         batch_ff     <= '0;
         life_ff      <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grav_ff      <= grav_in;
         mag_ff       <= mag_in;
         refr_ff      <= refr_in;
         prev_ff      <= prev_in;
         batch_ff     <= batch_in;
         life_ff      <= life_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      read_ok_ff  <= read_ok_in;
      level_ff    <= level_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      counted_ff  <= counted_in;
      check_ff    <= check_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("item accepted but sequencer stayed idle");

   a_life_only_in_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_STEP |=> $stable(life_ff) && $stable(batch_ff))
      else $error("step counts changed outside the step cycle");

   a_count_increments: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP && counted_in |=> batch_ff == $past(batch_ff) + COUNT_W'(1))
      else $error("counted step did not bump the batch count");

endmodule

`default_nettype wire
